### rtl/crt_pkg.sv
// Shared types, constants and the cosine table of the reciprocating trajectory block.
`timescale 1ns / 1ps
package crt_pkg;

  localparam int COS_TABLE_DEPTH = 256;
  localparam int POS_FRAC_BITS   = 16;

  localparam int POS_W   = 32;
  localparam int TICK_W  = 24;
  localparam int PER_W   = 16;
  localparam int NPER_W  = 8;
  localparam int STEP_W  = 24;
  localparam int CFG_W   = 32;

  localparam int COS_IDX_W = $clog2(COS_TABLE_DEPTH);
  localparam int FULL_W    = COS_IDX_W + 2;
  localparam int ROM_W     = POS_FRAC_BITS + 1;
  localparam int WGT_W     = POS_FRAC_BITS + 2;
  localparam int PROD_W    = POS_W + WGT_W;
  localparam int MAG_W     = POS_W + 2;
  localparam int SUM_W     = POS_W + 4;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [WGT_W-1:0] W_ONE = WGT_W'(1) << POS_FRAC_BITS;

  localparam logic [POS_W-1:0]  AMP_RST  = '0;
  localparam logic [PER_W-1:0]  PER_RST  = PER_W'(1000);
  localparam logic [NPER_W-1:0] NPER_RST = NPER_W'(2);
  localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(16777);

  typedef enum logic [1:0] {
    CFG_AMPLITUDE    = 2'd0,
    CFG_PERIOD_TICKS = 2'd1,
    CFG_NUM_PERIODS  = 2'd2,
    CFG_PHASE_STEP   = 2'd3
  } cfg_idx_e;

  typedef logic [COS_TABLE_DEPTH:0][ROM_W-1:0] cos_rom_t;

  typedef struct packed {
    logic signed [POS_W-1:0] amplitude;
    logic [PER_W-1:0]        period_ticks;
    logic [NPER_W-1:0]       num_periods;
    logic [STEP_W-1:0]       phase_step;
  } cfg_t;

  typedef struct packed {
    logic                    act;
    logic                    sub;
    logic                    mid;
    logic [STEP_W-1:0]       acc;
    logic signed [POS_W-1:0] base;
    logic signed [POS_W-1:0] amp;
    logic [TICK_W-1:0]       remaining;
    logic                    done;
  } ctl_t;

  typedef struct packed {
    logic                    act;
    logic                    neg;
    logic                    mid;
    logic [PROD_W-1:0]       prod;
    logic signed [POS_W-1:0] base;
    logic [TICK_W-1:0]       remaining;
    logic                    done;
  } mul_t;

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t    rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] mag;
    longint      sum;
    rom = '0;
    for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
      x   = (HALF_PI_Q30 * 64'(i)) / 64'(COS_TABLE_DEPTH);
      x2  = (x * x) >> 30;
      mag = 64'd1 << 30;
      sum = longint'(mag);
      for (int n = 1; n <= 12; n++) begin
        mag = ((mag * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
        if ((n & 1) != 0) begin
          sum = sum - longint'(mag);
        end else begin
          sum = sum + longint'(mag);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > (longint'(1) <<< 30)) begin
        sum = longint'(1) <<< 30;
      end
      rom[i] = ROM_W'((64'(sum) + (64'd1 << (29 - POS_FRAC_BITS))) >> (30 - POS_FRAC_BITS));
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

### rtl/crt_if.sv
// Handshake channel interfaces for ticks in and trajectory results out.
`timescale 1ns / 1ps
interface crt_in_if;
  logic                    valid;
  logic                    ready;
  logic                    start_req;
  logic signed [crt_pkg::POS_W-1:0] actual_pos;

  modport source (output valid, output start_req, output actual_pos, input ready);
  modport sink (input valid, input start_req, input actual_pos, output ready);
endinterface

interface crt_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [crt_pkg::POS_W-1:0]  target_pos;
  logic                              target_valid;
  logic [crt_pkg::TICK_W-1:0]        remaining;
  logic                              done_res;

  modport source (output valid, output target_pos, output target_valid, output remaining,
                  output done_res, input ready);
  modport sink (input valid, input target_pos, input target_valid, input remaining,
                input done_res, output ready);
endinterface

### rtl/crt_ctrl.sv
// Tick counter, phase decode, base latch and phase accumulator.
`timescale 1ns / 1ps
module crt_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  crt_pkg::cfg_t                    cfg_i,
  input  logic                             en_i,
  input  logic                             accept_i,
  input  logic                             start_req_i,
  input  logic signed [crt_pkg::POS_W-1:0] actual_pos_i,
  output logic                             vld_o,
  output crt_pkg::ctl_t                    ctl_o
);

  localparam int CW = crt_pkg::TICK_W + 1;

  logic [crt_pkg::TICK_W-1:0]       tick_q, tick_d;
  logic signed [crt_pkg::POS_W-1:0] base_q, base_d;
  logic [crt_pkg::STEP_W-1:0]       acc_q, acc_d;
  logic                             run_q, run_d;
  logic                             vld_q;
  crt_pkg::ctl_t                    ctl_q, ctl_d;

  logic          run_eff;
  logic [CW-1:0] total, half, c, chs;
  logic          ph1, ph2, ph3, first;

  always_comb begin
    total = CW'(cfg_i.num_periods) * CW'(cfg_i.period_ticks);
    half  = CW'(cfg_i.period_ticks >> 1);
    run_eff = start_req_i | run_q;
    if (start_req_i) begin
      tick_d = crt_pkg::TICK_W'(1);
    end else if (run_q) begin
      tick_d = tick_q + crt_pkg::TICK_W'(1);
    end else begin
      tick_d = tick_q;
    end
    c   = CW'(tick_d);
    chs = c + half;
    ph1 = (c >= CW'(1)) && (c <= half);
    ph2 = !ph1 && (c > half) && (chs <= total);
    ph3 = !ph1 && !ph2 && (chs > total) && (c <= total);
    first = (ph1 && (c == CW'(1))) || (ph2 && (c == half + CW'(1)))
         || (ph3 && (chs == total + CW'(1)));

    base_d = base_q;
    acc_d  = acc_q;
    run_d  = run_q;
    if (run_eff) begin
      if (ph1 || ph2 || ph3) begin
        if (first) begin
          base_d = actual_pos_i;
          acc_d  = cfg_i.phase_step;
        end else begin
          acc_d = acc_q + cfg_i.phase_step;
        end
      end
      run_d = !(c >= total);
    end

    ctl_d.act       = run_eff && (ph1 || ph2 || ph3);
    ctl_d.sub       = !ph1;
    ctl_d.mid       = ph2;
    ctl_d.acc       = acc_d;
    ctl_d.base      = base_d;
    ctl_d.amp       = cfg_i.amplitude;
    ctl_d.remaining = (total > c) ? crt_pkg::TICK_W'(total - c) : '0;
    ctl_d.done      = (c != '0) && (c >= total);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      base_q <= '0;
      acc_q  <= '0;
      run_q  <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      if (accept_i) begin
        tick_q <= tick_d;
        base_q <= base_d;
        acc_q  <= acc_d;
        run_q  <= run_d;
      end
      if (en_i) begin
        vld_q <= accept_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  assign vld_o = vld_q;
  assign ctl_o = ctl_q;

endmodule

### rtl/crt_cos.sv
// Quarter-wave cosine lookup, weight and amplitude multiply.
`timescale 1ns / 1ps
module crt_cos (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  crt_pkg::ctl_t ctl_i,
  output logic          vld_o,
  output crt_pkg::mul_t mul_o
);

  logic [crt_pkg::FULL_W-1:0]    full;
  logic [1:0]                    quad;
  logic [crt_pkg::COS_IDX_W-1:0] idx;
  logic [crt_pkg::COS_IDX_W:0]   ridx;
  logic [crt_pkg::ROM_W-1:0]     rv;
  logic [crt_pkg::WGT_W-1:0]     w;
  logic [crt_pkg::POS_W-1:0]     amag;
  logic                          vld_q;
  crt_pkg::mul_t                 mul_d, mul_q;

  always_comb begin
    full = ctl_i.acc[crt_pkg::STEP_W-1 -: crt_pkg::FULL_W];
    quad = full[crt_pkg::FULL_W-1 -: 2];
    idx  = full[crt_pkg::COS_IDX_W-1:0];
    if (quad[0]) begin
      ridx = (crt_pkg::COS_IDX_W+1)'(crt_pkg::COS_TABLE_DEPTH) - {1'b0, idx};
    end else begin
      ridx = {1'b0, idx};
    end
    rv = crt_pkg::COS_ROM[ridx];
    if (quad[1] ^ quad[0]) begin
      w = crt_pkg::W_ONE + crt_pkg::WGT_W'(rv);
    end else begin
      w = crt_pkg::W_ONE - crt_pkg::WGT_W'(rv);
    end
    amag = ctl_i.amp[crt_pkg::POS_W-1] ? crt_pkg::POS_W'(-ctl_i.amp)
                                       : crt_pkg::POS_W'(ctl_i.amp);
    mul_d.act       = ctl_i.act;
    mul_d.neg       = ctl_i.amp[crt_pkg::POS_W-1] ^ ctl_i.sub;
    mul_d.mid       = ctl_i.mid;
    mul_d.prod      = crt_pkg::PROD_W'(amag) * crt_pkg::PROD_W'(w);
    mul_d.base      = ctl_i.base;
    mul_d.remaining = ctl_i.remaining;
    mul_d.done      = ctl_i.done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mul_q <= mul_d;
    end
  end

  assign vld_o = vld_q;
  assign mul_o = mul_q;

endmodule

### rtl/crt_out.sv
// Offset rounding, signed add to the base, saturation and result register.
`timescale 1ns / 1ps
module crt_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  crt_pkg::mul_t  mul_i,
  crt_out_if.source      out_o
);

  localparam logic signed [crt_pkg::SUM_W-1:0] POS_MAX =
    crt_pkg::SUM_W'({1'b0, {(crt_pkg::POS_W-1){1'b1}}});
  localparam logic signed [crt_pkg::SUM_W-1:0] POS_MIN = -POS_MAX - crt_pkg::SUM_W'(1);

  logic [crt_pkg::PROD_W-1:0]        rnd;
  logic [crt_pkg::MAG_W-1:0]         mag;
  logic signed [crt_pkg::SUM_W-1:0]  off, sum;
  logic signed [crt_pkg::POS_W-1:0]  tgt_d, tgt_q;
  logic                              act_q, done_q, vld_q;
  logic [crt_pkg::TICK_W-1:0]        rem_q;

  always_comb begin
    if (mul_i.mid) begin
      rnd = mul_i.prod + (crt_pkg::PROD_W'(1) << (crt_pkg::POS_FRAC_BITS - 1));
      mag = crt_pkg::MAG_W'(rnd >> crt_pkg::POS_FRAC_BITS);
    end else begin
      rnd = mul_i.prod + (crt_pkg::PROD_W'(1) << crt_pkg::POS_FRAC_BITS);
      mag = crt_pkg::MAG_W'(rnd >> (crt_pkg::POS_FRAC_BITS + 1));
    end
    off = mul_i.neg ? -$signed(crt_pkg::SUM_W'(mag)) : $signed(crt_pkg::SUM_W'(mag));
    sum = crt_pkg::SUM_W'(mul_i.base) + off;
    if (!mul_i.act) begin
      tgt_d = mul_i.base;
    end else if (sum > POS_MAX) begin
      tgt_d = crt_pkg::POS_W'(POS_MAX);
    end else if (sum < POS_MIN) begin
      tgt_d = crt_pkg::POS_W'(POS_MIN);
    end else begin
      tgt_d = crt_pkg::POS_W'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tgt_q  <= tgt_d;
      act_q  <= mul_i.act;
      rem_q  <= mul_i.remaining;
      done_q <= mul_i.done;
    end
  end

  assign out_o.valid        = vld_q;
  assign out_o.target_pos   = tgt_q;
  assign out_o.target_valid = act_q;
  assign out_o.remaining    = rem_q;
  assign out_o.done_res     = done_q;

endmodule

### rtl/cosine_reciprocating_trajectory_top.sv
// Top level of the raised-cosine reciprocating trajectory generator.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    start_req, actual_pos
//   out_o    out  valid/ready    target_pos, target_valid, remaining, done_res
//   cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// One transaction in, one transaction out; a new tick is taken every cycle unless stalled.
// Results pass through the tick/phase stage, cosine table and multiply, round and add.
// The pipeline advances as a whole whenever the result register is empty or being taken.
// Reset clears tick count, base, phase accumulator, run flag and loads register defaults.
`timescale 1ns / 1ps
module cosine_reciprocating_trajectory_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [crt_pkg::CFG_W-1:0] cfg_data_i,
  crt_in_if.sink                   in_i,
  crt_out_if.source                out_o
);

  crt_pkg::cfg_t cfg_q;
  crt_pkg::ctl_t ctl;
  crt_pkg::mul_t mul;
  logic          en, accept, s1_vld, s2_vld;

  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;
  assign accept     = in_i.valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.amplitude    <= crt_pkg::AMP_RST;
      cfg_q.period_ticks <= crt_pkg::PER_RST;
      cfg_q.num_periods  <= crt_pkg::NPER_RST;
      cfg_q.phase_step   <= crt_pkg::STEP_RST;
    end else if (cfg_we_i) begin
      case (crt_pkg::cfg_idx_e'(cfg_idx_i))
        crt_pkg::CFG_AMPLITUDE:    cfg_q.amplitude    <= cfg_data_i;
        crt_pkg::CFG_PERIOD_TICKS: cfg_q.period_ticks <= cfg_data_i[crt_pkg::PER_W-1:0];
        crt_pkg::CFG_NUM_PERIODS:  cfg_q.num_periods  <= cfg_data_i[crt_pkg::NPER_W-1:0];
        crt_pkg::CFG_PHASE_STEP:   cfg_q.phase_step   <= cfg_data_i[crt_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  crt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .en_i         (en),
    .accept_i     (accept),
    .start_req_i  (in_i.start_req),
    .actual_pos_i (in_i.actual_pos),
    .vld_o        (s1_vld),
    .ctl_o        (ctl)
  );

  crt_cos u_cos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s1_vld),
    .ctl_i  (ctl),
    .vld_o  (s2_vld),
    .mul_o  (mul)
  );

  crt_out u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s2_vld),
    .mul_i  (mul),
    .out_o  (out_o)
  );

endmodule
